FILE: rtl/core/pcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the contingency counter
// Word layouts, configuration register indexes, lane control and FSM states.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int VAL_W          = 2;   // width of one category value
  localparam int NUM_IN_PARENTS = 4;   // parent values carried by a sample
  localparam int NP_W           = 3;   // effective parent count, 0..4
  localparam int CFG_W          = 3;   // configuration data width
  localparam int CFG_IDX_W      = 1;   // configuration register index width
  localparam int SLOT_W         = 3;
  localparam int TOTAL_W        = 4;
  localparam int OUT_CNT_W      = 16;
  localparam int OUT_CNTS       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CATEGORIES   = 1'b1;

  localparam logic [CFG_W-1:0] PARENT_COUNT_RST = 3'd1;
  localparam logic [CFG_W-1:0] CATEGORIES_RST   = 3'd4;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_ROW = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] parent_value_0;
    logic [VAL_W-1:0] parent_value_1;
    logic [VAL_W-1:0] parent_value_2;
    logic [VAL_W-1:0] parent_value_3;
    logic [VAL_W-1:0] child_value;
    logic             last_sample;
  } sample_t;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_W-1:0]    slot;
    logic                 is_new;
    logic                 table_full;
    logic                 bad_value;
    logic [OUT_CNT_W-1:0] count_0;
    logic [OUT_CNT_W-1:0] count_1;
    logic [OUT_CNT_W-1:0] count_2;
    logic [OUT_CNT_W-1:0] count_3;
    logic [TOTAL_W-1:0]   config_total;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic append;  // write key, start counts with the child at one
    logic bump;    // saturating increment of the child's count
  } lane_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_OUT
  } pcc_state_e;

endpackage
`default_nettype wire

FILE: rtl/core/pcc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_lane: one configuration table entry
// Holds a parent key and its child-category counts, compares the key against
// the current sample and applies append or increment.
// ----------------------------------------------------------------------------
module pcc_lane #(
  parameter int KEY_PARENTS = 4,
  parameter int NUM_CNT     = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                                                 clk_i,
  input  pcc_pkg::lane_ctl_t                                  ctl_i,
  input  wire                                                 active_i,
  input  wire  [pcc_pkg::NP_W-1:0]                            np_i,
  input  wire  [pcc_pkg::NUM_IN_PARENTS-1:0][pcc_pkg::VAL_W-1:0] pv_i,
  input  wire  [pcc_pkg::VAL_W-1:0]                           child_i,
  output logic                                                hit_o,
  output logic [NUM_CNT-1:0][COUNT_WIDTH-1:0]                 cnt_o,
  output logic [NUM_CNT-1:0][COUNT_WIDTH-1:0]                 cnt_next_o
);
  import pcc_pkg::*;

  logic [KEY_PARENTS-1:0][VAL_W-1:0] key_q;
  logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] cnt_q, cnt_d;

  always_comb begin
    hit_o = active_i;
    for (int i = 0; i < KEY_PARENTS; i++) begin
      if (NP_W'(i) < np_i && key_q[i] != pv_i[i]) hit_o = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int j = 0; j < NUM_CNT; j++) begin
      if (ctl_i.append) begin
        cnt_d[j] = (VAL_W'(j) == child_i) ? COUNT_WIDTH'(1) : '0;
      end else if (ctl_i.bump && VAL_W'(j) == child_i && cnt_q[j] != '1) begin
        cnt_d[j] = cnt_q[j] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.append) begin
      for (int i = 0; i < KEY_PARENTS; i++) key_q[i] <= pv_i[i];
    end
    cnt_q <= cnt_d;
  end

  assign cnt_o      = cnt_q;
  assign cnt_next_o = cnt_d;

endmodule
`default_nettype wire

FILE: rtl/core/pcc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_merge: combines lane compare results
// Picks the lowest matching entry, which is the earliest configuration seen.
// ----------------------------------------------------------------------------
module pcc_merge #(
  parameter int LANES = 8
) (
  input  wire  [LANES-1:0]         hit_i,
  output logic                     found_o,
  output logic [$clog2(LANES)-1:0] idx_o
);
  localparam int IDX_W = $clog2(LANES);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (hit_i[k]) begin
        found_o = 1'b1;
        idx_o   = IDX_W'(k);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/parent_config_contingency_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// parent_config_contingency_counter: parent-configuration contingency table
// Counts child categories per distinct parent configuration, acknowledges
// every sample and dumps the table on the last sample of a data set.
// ----------------------------------------------------------------------------
// A sample word goes through ST_IDLE, which accepts it; ST_EVAL, in which
// every table entry compares its key in its own lane, the merge picks the
// first match (or an entry is appended) and the ack word is registered;
// and ST_OUT, which hands it over when out_ready_i is high. A word marked
// last_sample adds one dump row per used entry, after which the table is empty.
// The block takes one sample at a time; in_ready_o is low from acceptance
// until the last result of that sample has been taken. A sample with a value
// at or above the category count, or one needing a new entry when all
// MAX_CONFIGS entries are in use, changes no entry and is flagged in its
// acknowledgement. Counts saturate at 2^COUNT_WIDTH-1 and show as at most
// 65535. Keys and counts need no reset: an entry is written when appended.
// The user must write configuration only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module parent_config_contingency_counter #(
  parameter int PARENT_LIMIT   = 4,
  parameter int MAX_CONFIGS    = 8,
  parameter int MAX_CATEGORIES = 4,
  parameter int COUNT_WIDTH    = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [pcc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [pcc_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  pcc_pkg::sample_t                 in_word_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output pcc_pkg::result_t                 out_word_o
);
  import pcc_pkg::*;

  localparam int KEY_PARENTS = (PARENT_LIMIT < NUM_IN_PARENTS) ? PARENT_LIMIT : NUM_IN_PARENTS;
  localparam int NUM_CNT     = (MAX_CATEGORIES < OUT_CNTS) ? MAX_CATEGORIES : OUT_CNTS;
  localparam int LANE_W      = $clog2(MAX_CONFIGS);
  localparam int USED_W      = $clog2(MAX_CONFIGS + 1);

  typedef logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] lane_cnt_t;
  typedef logic [OUT_CNTS-1:0][OUT_CNT_W-1:0]  out_cnt_t;

  // Clamp counts to the 16-bit output fields; missing categories read 0.
  function automatic out_cnt_t fmt_counts(input lane_cnt_t c);
    out_cnt_t    r;
    logic [31:0] ext;
    r = '0;
    for (int j = 0; j < NUM_CNT; j++) begin
      ext  = 32'(c[j]);
      r[j] = (ext > 32'hFFFF) ? '1 : ext[OUT_CNT_W-1:0];
    end
    return r;
  endfunction

  pcc_state_e state_q, state_d;

  logic [CFG_W-1:0]  parent_count_q, categories_q;
  logic [USED_W-1:0] used_q, used_next, dump_idx_q;
  logic              last_q;
  sample_t           sample_q;
  result_t           out_q;

  logic [NP_W-1:0]  np;
  logic [CFG_W-1:0] nc;
  logic [NUM_IN_PARENTS-1:0][VAL_W-1:0] pv;

  logic bad, found, need_new, full_tbl, do_append, ok;
  logic [LANE_W-1:0] hit_idx, slot_sel, row_idx;
  logic ld_ack, ld_row, clr_used;

  logic [MAX_CONFIGS-1:0] hit_vec, app_vec, bump_vec;
  lane_cnt_t lane_cnt_q [MAX_CONFIGS];
  lane_cnt_t lane_cnt_d [MAX_CONFIGS];
  lane_ctl_t lane_ctl   [MAX_CONFIGS];

  result_t  ack_w, row_w;
  out_cnt_t ack_cnt, row_cnt;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parent_count_q <= PARENT_COUNT_RST;
      categories_q   <= CATEGORIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PARENT_COUNT: parent_count_q <= cfg_data_i;
        CFG_CATEGORIES:   categories_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective parent and category counts
  assign np = (int'(parent_count_q) > KEY_PARENTS) ? NP_W'(KEY_PARENTS)
                                                    : NP_W'(parent_count_q);
  assign nc = (int'(categories_q) > MAX_CATEGORIES) ? CFG_W'(MAX_CATEGORIES)
                                                     : categories_q;

  assign pv[0] = sample_q.parent_value_0;
  assign pv[1] = sample_q.parent_value_1;
  assign pv[2] = sample_q.parent_value_2;
  assign pv[3] = sample_q.parent_value_3;

  // Range check of every used value
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < NUM_IN_PARENTS; i++) begin
      if (NP_W'(i) < np && {1'b0, pv[i]} >= nc) bad = 1'b1;
    end
    if ({1'b0, sample_q.child_value} >= nc) bad = 1'b1;
  end

  // One lane per table entry
  for (genvar k = 0; k < MAX_CONFIGS; k++) begin : g_lane
    assign app_vec[k]  = ld_ack & do_append & (USED_W'(k) == used_q);
    assign bump_vec[k] = ld_ack & ok & found & (hit_idx == LANE_W'(k));
    assign lane_ctl[k] = '{append: app_vec[k], bump: bump_vec[k]};

    pcc_lane #(
      .KEY_PARENTS (KEY_PARENTS),
      .NUM_CNT     (NUM_CNT),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i      (clk_i),
      .ctl_i      (lane_ctl[k]),
      .active_i   (USED_W'(k) < used_q),
      .np_i       (np),
      .pv_i       (pv),
      .child_i    (sample_q.child_value),
      .hit_o      (hit_vec[k]),
      .cnt_o      (lane_cnt_q[k]),
      .cnt_next_o (lane_cnt_d[k])
    );
  end

  pcc_merge #(
    .LANES (MAX_CONFIGS)
  ) u_merge (
    .hit_i   (hit_vec),
    .found_o (found),
    .idx_o   (hit_idx)
  );

  // Match, append or drop
  assign need_new  = ~bad & ~found;
  assign full_tbl  = need_new & (used_q == USED_W'(MAX_CONFIGS));
  assign do_append = need_new & ~full_tbl;
  assign ok        = ~bad & ~full_tbl;
  assign slot_sel  = found ? hit_idx : used_q[LANE_W-1:0];
  assign used_next = do_append ? USED_W'(used_q + 1'b1) : used_q;

  // Acknowledgement word: counts after the update
  assign ack_cnt = ok ? fmt_counts(lane_cnt_d[slot_sel]) : '0;
  always_comb begin
    ack_w              = '0;
    ack_w.kind         = KIND_ACK;
    ack_w.slot         = ok ? SLOT_W'(slot_sel) : '0;
    ack_w.is_new       = do_append;
    ack_w.table_full   = full_tbl;
    ack_w.bad_value    = bad;
    ack_w.count_0      = ack_cnt[0];
    ack_w.count_1      = ack_cnt[1];
    ack_w.count_2      = ack_cnt[2];
    ack_w.count_3      = ack_cnt[3];
    ack_w.config_total = TOTAL_W'(used_next);
    ack_w.last         = ~sample_q.last_sample;
  end

  // Dump row word
  assign row_idx = dump_idx_q[LANE_W-1:0];
  assign row_cnt = fmt_counts(lane_cnt_q[row_idx]);
  always_comb begin
    row_w              = '0;
    row_w.kind         = KIND_ROW;
    row_w.slot         = SLOT_W'(dump_idx_q);
    row_w.count_0      = row_cnt[0];
    row_w.count_1      = row_cnt[1];
    row_w.count_2      = row_cnt[2];
    row_w.count_3      = row_cnt[3];
    row_w.config_total = TOTAL_W'(used_q);
    row_w.last         = (USED_W'(dump_idx_q + 1'b1) == used_q);
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    ld_ack   = 1'b0;
    ld_row   = 1'b0;
    clr_used = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        ld_ack  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (last_q && dump_idx_q < used_q) begin
            ld_row = 1'b1;
          end else begin
            state_d  = ST_IDLE;
            clr_used = last_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      last_q     <= 1'b0;
      dump_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (ld_ack) begin
        used_q     <= used_next;
        last_q     <= sample_q.last_sample;
        dump_idx_q <= '0;
      end else begin
        if (clr_used) used_q <= '0;
        if (ld_row) dump_idx_q <= USED_W'(dump_idx_q + 1'b1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sample_q <= in_word_i;
    if (ld_ack) out_q <= ack_w;
    else if (ld_row) out_q <= row_w;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_word_o  = out_q;

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(MAX_CONFIGS))
    else $error("entry count beyond table size");

  a_one_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(app_vec) && $onehot0(bump_vec) && !((app_vec | bump_vec) == '0 && ld_ack && ok))
    else $error("lane update not exactly one entry");

  a_row_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_ROW |-> last_q)
    else $error("dump row without last sample");

  a_clear_after_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_used |=> used_q == '0 && in_ready_o)
    else $error("table not emptied after dump");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the parent-configuration contingency counter
// Offers sample words with random gaps on both sides and keeps its own copy
// of the configuration table. Every acknowledgement and dump row is checked
// in order against that copy, or against a typed value on directed rows.
// ----------------------------------------------------------------------------
module tb;
  import pcc_pkg::*;

  localparam int MAX_CFGS      = 8;         // table entries of the default build
  localparam int MAX_CATS      = 4;         // count lanes of the default build
  localparam int CYCLE_LIMIT   = 200_000;   // watchdog limit for a run that stops making progress
  localparam int ERR_PRINT_CAP = 50;
  localparam int POOL_KEYS     = 10;        // more keys than entries, so the table fills

  // one row of the directed table: a register write or a sample word
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    int                   reg_val;
    sample_t              word;
    bit                   pinned;  // ack typed in below instead of predicted
    result_t              ack;
  } plan_step_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  sample_t              in_word   = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  result_t              out_word;

  // predictor state: keys, per-category tallies, entry count, registers
  logic [VAL_W-1:0] key_tbl [MAX_CFGS][NUM_IN_PARENTS];
  logic [15:0]      tally   [MAX_CFGS][MAX_CATS];
  int               used_cnt;
  logic [CFG_W-1:0] pc_reg;
  logic [CFG_W-1:0] cat_reg;
  result_t          pending_results[$];

  plan_step_t  plan[$];
  bit          pin_on;
  result_t     pin_ack;
  int          ack_pos;
  int          tx_idle_pct = 25;
  int          rx_idle_pct = 63;
  int          rx_hold_left;
  int unsigned cycle_cnt;
  int          err_cnt;
  int          words_in;
  int          words_out;
  int          dump_rows;
  int          settings_seen;

  parent_config_contingency_counter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timeout: no progress within %0d cycles", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Builders for sample and acknowledgement words
  // ---------------------------------------------------------------------------
  function automatic sample_t mk_word(int p0, int p1, int p2, int p3, int c, bit l);
    sample_t w;
    w.parent_value_0 = p0[VAL_W-1:0];
    w.parent_value_1 = p1[VAL_W-1:0];
    w.parent_value_2 = p2[VAL_W-1:0];
    w.parent_value_3 = p3[VAL_W-1:0];
    w.child_value    = c[VAL_W-1:0];
    w.last_sample    = l;
    return w;
  endfunction

  function automatic result_t mk_ack(int slot, bit fresh, bit full, bit bad,
                                     int c0, int c1, int c2, int c3, int total, bit lst);
    result_t r;
    r.kind         = KIND_ACK;
    r.slot         = slot[SLOT_W-1:0];
    r.is_new       = fresh;
    r.table_full   = full;
    r.bad_value    = bad;
    r.count_0      = c0[OUT_CNT_W-1:0];
    r.count_1      = c1[OUT_CNT_W-1:0];
    r.count_2      = c2[OUT_CNT_W-1:0];
    r.count_3      = c3[OUT_CNT_W-1:0];
    r.config_total = total[TOTAL_W-1:0];
    r.last         = lst;
    return r;
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, int val);
    plan_step_t p;
    p = '{default: '0};
    p.is_cfg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    plan.push_back(p);
  endfunction

  function automatic void plan_word(sample_t w, bit pinned, result_t a);
    plan_step_t p;
    p = '{default: '0};
    p.word   = w;
    p.pinned = pinned;
    p.ack    = a;
    plan.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: match or append the parent key, bump the child tally, queue the
  // ack and, on a last sample, one row per entry before emptying the table.
  // ---------------------------------------------------------------------------
  function automatic void tally_sample(sample_t w);
    logic [VAL_W-1:0] pv [NUM_IN_PARENTS];
    int      np, nc, child, slot, i, s;
    bit      bad, full, fresh, found, same;
    result_t r;
    pv[0] = w.parent_value_0;
    pv[1] = w.parent_value_1;
    pv[2] = w.parent_value_2;
    pv[3] = w.parent_value_3;
    child = w.child_value;
    np    = (pc_reg > NUM_IN_PARENTS) ? NUM_IN_PARENTS : pc_reg;
    nc    = (cat_reg > MAX_CATS) ? MAX_CATS : cat_reg;
    bad   = (child >= nc);
    for (i = 0; i < np; i++)
      if (pv[i] >= nc) bad = 1'b1;
    slot  = 0;
    full  = 1'b0;
    fresh = 1'b0;
    if (!bad) begin
      found = 1'b0;
      for (s = 0; s < used_cnt && !found; s++) begin
        same = 1'b1;
        for (i = 0; i < np; i++)
          if (key_tbl[s][i] != pv[i]) same = 1'b0;
        if (same) begin
          found = 1'b1;
          slot  = s;
        end
      end
      if (!found) begin
        if (used_cnt >= MAX_CFGS) begin
          full = 1'b1;
        end else begin
          slot = used_cnt;
          for (i = 0; i < NUM_IN_PARENTS; i++) key_tbl[slot][i] = pv[i];
          for (i = 0; i < MAX_CATS; i++) tally[slot][i] = '0;
          used_cnt++;
          fresh = 1'b1;
        end
      end
      // saturate at the top of the 16-bit range
      if (!full && tally[slot][child] != 16'hFFFF) tally[slot][child]++;
    end

    // dropped words report zeros apart from the flags and the entry count
    if (bad || full)
      r = mk_ack(0, 1'b0, full, bad, 0, 0, 0, 0, used_cnt, !w.last_sample);
    else
      r = mk_ack(slot, fresh, 1'b0, 1'b0, tally[slot][0], tally[slot][1],
                 tally[slot][2], tally[slot][3], used_cnt, !w.last_sample);
    pending_results.push_back(r);

    if (w.last_sample) begin
      for (s = 0; s < used_cnt; s++) begin
        r      = mk_ack(s, 1'b0, 1'b0, 1'b0, tally[s][0], tally[s][1], tally[s][2],
                        tally[s][3], used_cnt, s + 1 == used_cnt);
        r.kind = KIND_ROW;
        pending_results.push_back(r);
      end
      used_cnt = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag(string what, logic [79:0] got, logic [79:0] want);
    err_cnt++;
    if (err_cnt <= ERR_PRINT_CAP)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      flag("unexpected result word", got, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind)                 flag("kind", got.kind, want.kind);
    if (got.slot !== want.slot)                 flag("slot", got.slot, want.slot);
    if (got.is_new !== want.is_new)             flag("is_new", got.is_new, want.is_new);
    if (got.table_full !== want.table_full)     flag("table_full", got.table_full,
                                                     want.table_full);
    if (got.bad_value !== want.bad_value)       flag("bad_value", got.bad_value,
                                                     want.bad_value);
    if (got.count_0 !== want.count_0)           flag("count_0", got.count_0, want.count_0);
    if (got.count_1 !== want.count_1)           flag("count_1", got.count_1, want.count_1);
    if (got.count_2 !== want.count_2)           flag("count_2", got.count_2, want.count_2);
    if (got.count_3 !== want.count_3)           flag("count_3", got.count_3, want.count_3);
    if (got.config_total !== want.config_total) flag("config_total", got.config_total,
                                                     want.config_total);
    if (got.last !== want.last)                 flag("last", got.last, want.last);
  endtask

  // Everything the block sees is taken at the rising edge: register writes,
  // accepted samples (predicted first) and accepted result words.
  always @(posedge clk) begin
    if (!rst_n) begin
      used_cnt = 0;
      pc_reg   = PARENT_COUNT_RST;
      cat_reg  = CATEGORIES_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PARENT_COUNT: pc_reg  = cfg_data;
          CFG_CATEGORIES:   cat_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ack_pos = pending_results.size();
        tally_sample(in_word);
        if (pin_on) pending_results[ack_pos] = pin_ack;
        pin_on = 1'b0;
        words_in++;
      end
      if (out_valid && out_ready) begin
        if (out_word.kind == KIND_ROW) dump_rows++;
        words_out++;
        check_result(out_word);
      end
    end
  end

  // Receiver: random backpressure, or a long hold-off counted down here while
  // the sender keeps offering words.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one word and return at the edge that takes it. Valid stays up until
  // the next call or drain decides at the following falling edge.
  task automatic offer(sample_t w, bit pinned, result_t a);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pin_on   = pinned;
    pin_ack  = a;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Idle the input and wait until every predicted word has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Data sets: mostly in-range words drawn from a small key pool so entries
  // repeat and the table can fill, with some stray values and raw noise.
  task automatic run_data_sets(int n_words);
    logic [VAL_W-1:0] pool [POOL_KEYS][NUM_IN_PARENTS];
    logic [10:0]      raw;
    int               left, set_len, k, i, np, nc, pick;
    sample_t          w;
    left = n_words;
    np   = (pc_reg > NUM_IN_PARENTS) ? NUM_IN_PARENTS : pc_reg;
    nc   = (cat_reg > MAX_CATS) ? MAX_CATS : cat_reg;
    while (left > 0) begin
      set_len = $urandom_range(1, 20);
      for (k = 0; k < POOL_KEYS; k++)
        for (i = 0; i < NUM_IN_PARENTS; i++)
          pool[k][i] = VAL_W'((i < np && nc > 0) ? $urandom_range(nc - 1)
                                                 : $urandom_range(3));
      for (k = 0; k < set_len && left > 0; k++) begin
        left--;
        if ($urandom_range(9) == 0) begin
          raw = 11'($urandom);
          w   = raw;
        end else begin
          pick = $urandom_range(POOL_KEYS - 1);
          w = mk_word(pool[pick][0], pool[pick][1], pool[pick][2], pool[pick][3],
                      (nc > 0) ? $urandom_range(nc - 1) : $urandom_range(3),
                      k == set_len - 1);
          // occasional out-of-range value in a well-formed set
          if ($urandom_range(24) == 0) w.parent_value_0 = VAL_W'($urandom_range(3));
          if ($urandom_range(24) == 0) w.child_value    = VAL_W'($urandom_range(3));
        end
        offer(w, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int      pc_set  [8];
    int      cat_set [8];
    int      ph;
    result_t lost;
    pc_set  = '{2, 4, 3, 0, 7, 4, 1, 5};
    cat_set = '{3, 4, 2, 4, 7, 2, 1, 3};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Reset settings first: one parent compared, four values.
    plan_word(mk_word(0, 0, 0, 0, 0, 0), 1, mk_ack(0, 1, 0, 0, 1, 0, 0, 0, 1, 1));
    plan_word(mk_word(0, 3, 3, 3, 3, 0), 1, mk_ack(0, 0, 0, 0, 1, 0, 0, 1, 1, 1));
    plan_word(mk_word(3, 0, 0, 0, 1, 0), 1, mk_ack(1, 1, 0, 0, 0, 1, 0, 0, 2, 1));
    // two values only: parent or child at 2 and above is dropped
    plan_reg(CFG_CATEGORIES, 2);
    plan_word(mk_word(2, 0, 0, 0, 0, 0), 1, mk_ack(0, 0, 0, 1, 0, 0, 0, 0, 2, 1));
    plan_word(mk_word(1, 0, 0, 0, 3, 0), 1, mk_ack(0, 0, 0, 1, 0, 0, 0, 0, 2, 1));
    plan_word(mk_word(1, 2, 2, 2, 1, 1), 0, '0);
    // all four parents: fill every entry, overflow once, then dump a full table
    plan_reg(CFG_PARENT_COUNT, 4);
    plan_reg(CFG_CATEGORIES, 4);
    plan_word(mk_word(0, 0, 0, 0, 0, 0), 0, '0);
    plan_word(mk_word(3, 3, 3, 3, 3, 0), 0, '0);
    plan_word(mk_word(1, 2, 3, 0, 1, 0), 0, '0);
    plan_word(mk_word(0, 1, 2, 3, 2, 0), 0, '0);
    plan_word(mk_word(3, 0, 0, 0, 3, 0), 0, '0);
    plan_word(mk_word(0, 0, 0, 3, 0, 0), 0, '0);
    plan_word(mk_word(2, 2, 2, 2, 1, 0), 0, '0);
    plan_word(mk_word(1, 1, 1, 1, 2, 0), 0, '0);
    plan_word(mk_word(2, 1, 0, 3, 2, 0), 1, mk_ack(0, 0, 1, 0, 0, 0, 0, 0, 8, 1));
    plan_word(mk_word(3, 3, 3, 3, 2, 1), 0, '0);
    // no parents compared: every word shares entry 0
    plan_reg(CFG_PARENT_COUNT, 0);
    plan_word(mk_word(3, 3, 3, 3, 3, 0), 1, mk_ack(0, 1, 0, 0, 0, 0, 0, 1, 1, 1));
    plan_word(mk_word(1, 0, 2, 1, 0, 0), 0, '0);
    // one value: only child 0 passes; none: dropped even on the last word
    plan_reg(CFG_CATEGORIES, 1);
    plan_word(mk_word(2, 2, 2, 2, 1, 0), 1, mk_ack(0, 0, 0, 1, 0, 0, 0, 0, 1, 1));
    plan_word(mk_word(3, 1, 2, 0, 0, 0), 0, '0);
    plan_reg(CFG_CATEGORIES, 0);
    plan_word(mk_word(0, 0, 0, 0, 0, 1), 1, mk_ack(0, 0, 0, 1, 0, 0, 0, 0, 1, 0));

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        drain();
        write_reg(plan[n].reg_idx, plan[n].reg_val);
        settings_seen++;
      end else begin
        offer(plan[n].word, plan[n].pinned, plan[n].ack);
      end
    end

    // Random sets under several settings; gap pattern flips halfway.
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 4) begin
        tx_idle_pct = 63;
        rx_idle_pct = 25;
      end
      drain();
      write_reg(CFG_PARENT_COUNT, pc_set[ph]);
      write_reg(CFG_CATEGORIES, cat_set[ph]);
      settings_seen++;
      run_data_sets(45);
    end

    // No gaps; the receiver stalls long enough for the input side to back up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    drain();
    write_reg(CFG_PARENT_COUNT, 4);
    write_reg(CFG_CATEGORIES, 4);
    settings_seen++;
    @(posedge clk);
    rx_hold_left = 300;
    run_data_sets(40);

    drain();
    repeat (40) @(posedge clk);
    while (pending_results.size() != 0) begin
      lost = pending_results.pop_front();
      flag("result word never arrived, kind", lost.kind, '0);
    end

    $display("Covered %0d sample words and %0d result words (%0d dump rows)",
             words_in, words_out, dump_rows);
    $display("over %0d register settings, incl. full table, drops and a long stall",
             settings_seen);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: parent_config_contingency_counter.f
rtl/core/pcc_pkg.sv
rtl/core/pcc_lane.sv
rtl/core/pcc_merge.sv
rtl/core/parent_config_contingency_counter.sv
sim/tb.sv
